>>> hw/rtl/assert_macros.svh
// assertion macros for the range coalescer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/brsc_pkg.sv
// shared types and codes for the byte range set coalescer
// no dependencies
package brsc_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } brsc_state_e;

  // where the scan stands relative to the new range
  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_MERGE,
    PH_AFTER
  } brsc_phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } brsc_status_e;

  typedef struct packed {
    logic [47:0] offset;
    logic [31:0] extent;
  } brsc_req_t;

  typedef struct packed {
    logic [6:0]   count;
    logic [47:0]  total;
    logic [47:0]  span;
    brsc_status_e status;
  } brsc_result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } brsc_seq_stat_t;

endpackage

>>> hw/rtl/byte_range_set_coalescer_unit.sv
// byte range set coalescer: top level with request handshake and result register
// an insert scans the stored ranges in order from request to result, bounded by the
// single read port of the range table (one entry per cycle); out of range skips the scan
// one request at a time; a new request is taken while the last result waits
// reset empties the table (count and total cleared); table contents need no clearing
module byte_range_set_coalescer_unit #(
  parameter int MAX_RANGES  = 64,
  parameter int OFFSET_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] region_offset_i,
  input  logic [31:0] region_extent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  range_count_o,
  output logic [47:0] covered_bytes_o,
  output logic [47:0] covered_span_o,
  output logic [1:0]  status_o
);

  import brsc_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);
  localparam int DW = 2 * OFFSET_BITS;

  brsc_req_t      req;
  brsc_result_t   res;
  brsc_seq_stat_t stat;
  brsc_result_t   out_q;
  logic           out_valid_q;
  logic           start;
  logic           ack;

  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  logic [DW-1:0] mem_rdata, mem_wdata;

  assign in_stall_o = !stat.idle;
  assign start      = in_valid_i && !in_stall_o;
  assign req.offset = region_offset_i;
  assign req.extent = region_extent_i;

  // result slot is free or being emptied this cycle
  assign ack = stat.done && (!out_valid_q || !out_stall_i);

  brsc_merge_seq #(
    .MAX_RANGES (MAX_RANGES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .ack_i      (ack),
    .stat_o     (stat),
    .res_o      (res),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  brsc_range_mem #(
    .DEPTH(MAX_RANGES),
    .AW   (IW),
    .DW   (DW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ack || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign range_count_o   = out_q.count;
  assign covered_bytes_o = out_q.total;
  assign covered_span_o  = out_q.span;
  assign status_o        = out_q.status;

endmodule

>>> hw/rtl/brsc_range_mem.sv
// range table storage: one write port, one registered read port
// no package dependencies
module brsc_range_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 96
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/brsc_merge_seq.sv
// insert sequencer: scans the table, merges the new range and compacts in one pass
// depends on brsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module brsc_merge_seq #(
  parameter int MAX_RANGES  = 64,
  parameter int OFFSET_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  brsc_pkg::brsc_req_t                 req_i,
  input  logic                                ack_i,
  output brsc_pkg::brsc_seq_stat_t            stat_o,
  output brsc_pkg::brsc_result_t              res_o,
  output logic                                mem_re_o,
  output logic [$clog2(MAX_RANGES)-1:0]       mem_raddr_o,
  input  logic [2*OFFSET_BITS-1:0]            mem_rdata_i,
  output logic                                mem_we_o,
  output logic [$clog2(MAX_RANGES)-1:0]       mem_waddr_o,
  output logic [2*OFFSET_BITS-1:0]            mem_wdata_o
);

  import brsc_pkg::*;

  localparam int EW = OFFSET_BITS;
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [63:0]   OfsLimit = {64{1'b1}} >> (64 - OFFSET_BITS);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_RANGES);

  brsc_state_e  state_q, state_d;
  brsc_phase_e  phase_q, phase_d;
  brsc_status_e status_q, status_d;

  logic [EW-1:0] off_q, off_d;
  logic [EW-1:0] ns_q, ns_d;
  logic [EW-1:0] ne_q, ne_d;
  logic [EW-1:0] prev_s_q, prev_s_d;
  logic [EW-1:0] prev_e_q, prev_e_d;
  logic          prev_v_q, prev_v_d;
  logic [EW-1:0] held_s_q, held_s_d;
  logic [EW-1:0] held_e_q, held_e_d;
  logic [EW-1:0] removed_q, removed_d;
  logic [EW-1:0] len_q, len_d;
  logic          abs_q, abs_d;
  logic [CW-1:0] rptr_q, rptr_d;
  logic          rdv_q, rdv_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] count_q, count_d;
  logic [EW-1:0] total_q, total_d;
  logic [EW-1:0] head_q, head_d;
  logic [EW-1:0] tail_q, tail_d;

  logic [48:0]   sum_w;
  logic          range_err;
  logic [EW-1:0] rd_s, rd_e;
  logic          at_end;
  logic          take;
  logic          mem_re;
  logic          mem_we;
  logic [EW-1:0] span_w;
  logic [63:0]   count64, total64, span64;

  assign sum_w     = {1'b0, req_i.offset} + {17'd0, req_i.extent};
  assign range_err = 64'(sum_w) > OfsLimit;

  assign rd_s   = mem_rdata_i[2*EW-1:EW];
  assign rd_e   = mem_rdata_i[EW-1:0];
  // every entry has been read and handled
  assign at_end = !rdv_q && (rptr_q == count_q);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    status_d  = status_q;
    off_d     = off_q;
    ns_d      = ns_q;
    ne_d      = ne_q;
    prev_s_d  = prev_s_q;
    prev_e_d  = prev_e_q;
    prev_v_d  = prev_v_q;
    held_s_d  = held_s_q;
    held_e_d  = held_e_q;
    removed_d = removed_q;
    len_d     = len_q;
    abs_d     = abs_q;
    rptr_d    = rptr_q;
    rdv_d     = rdv_q;
    w_d       = w_q;
    count_d   = count_q;
    total_d   = total_q;
    head_d    = head_q;
    tail_d    = tail_q;
    take      = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rptr_d    = '0;
          rdv_d     = 1'b0;
          w_d       = '0;
          prev_v_d  = 1'b0;
          abs_d     = 1'b0;
          removed_d = '0;
          phase_d   = PH_BEFORE;
          if (range_err) begin
            status_d = ST_RANGE;
            state_d  = S_DONE;
          end else begin
            off_d   = EW'(req_i.offset);
            ne_d    = EW'(sum_w);
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        unique case (phase_q)
          PH_BEFORE: begin
            if (rdv_q && rd_s <= off_q) begin
              // candidate for the range just below the new offset
              prev_s_d = rd_s;
              prev_e_d = rd_e;
              prev_v_d = 1'b1;
              w_d      = w_q + 1'b1;
              take     = 1'b1;
            end else if (rdv_q || at_end) begin
              if (prev_v_q && off_q <= prev_e_q) begin
                ns_d      = prev_s_q;
                ne_d      = (prev_e_q > ne_q) ? prev_e_q : ne_q;
                removed_d = prev_e_q - prev_s_q;
                abs_d     = 1'b1;
                w_d       = w_q - 1'b1;
              end else begin
                ns_d = off_q;
              end
              phase_d = PH_MERGE;
            end
          end

          PH_MERGE: begin
            if (rdv_q && rd_s <= ne_q) begin
              ne_d      = (rd_e > ne_q) ? rd_e : ne_q;
              removed_d = removed_q + (rd_e - rd_s);
              abs_d     = 1'b1;
              take      = 1'b1;
            end else if (rdv_q || at_end) begin
              if (!abs_q && count_q == MaxCount) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                held_s_d  = ns_q;
                held_e_d  = ne_q;
                removed_d = total_q - removed_q;
                len_d     = ne_q - ns_q;
                if (w_q == '0) begin
                  head_d = ns_q;
                end
                phase_d = PH_AFTER;
              end
            end
          end

          PH_AFTER: begin
            if (rdv_q) begin
              // write the held entry, then hold the one just read
              mem_we   = 1'b1;
              w_d      = w_q + 1'b1;
              held_s_d = rd_s;
              held_e_d = rd_e;
              take     = 1'b1;
            end else if (at_end) begin
              state_d = S_FLUSH;
            end
          end

          default: ;
        endcase

        mem_re = (!rdv_q || take) && (rptr_q < count_q);
        if (mem_re) begin
          rptr_d = rptr_q + 1'b1;
          rdv_d  = 1'b1;
        end else if (take) begin
          rdv_d = 1'b0;
        end
      end

      S_FLUSH: begin
        mem_we   = 1'b1;
        count_d  = w_q + 1'b1;
        tail_d   = held_e_q;
        total_d  = removed_q + len_q;
        status_d = ST_OK;
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_BEFORE;
      rdv_q    <= 1'b0;
      prev_v_q <= 1'b0;
      abs_q    <= 1'b0;
      rptr_q   <= '0;
      w_q      <= '0;
      count_q  <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      rdv_q    <= rdv_d;
      prev_v_q <= prev_v_d;
      abs_q    <= abs_d;
      rptr_q   <= rptr_d;
      w_q      <= w_d;
      count_q  <= count_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    off_q     <= off_d;
    ns_q      <= ns_d;
    ne_q      <= ne_d;
    prev_s_q  <= prev_s_d;
    prev_e_q  <= prev_e_d;
    held_s_q  <= held_s_d;
    held_e_q  <= held_e_d;
    removed_q <= removed_d;
    len_q     <= len_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
  end

  assign mem_re_o    = mem_re;
  assign mem_raddr_o = rptr_q[IW-1:0];
  assign mem_we_o    = mem_we;
  assign mem_waddr_o = w_q[IW-1:0];
  assign mem_wdata_o = {held_s_q, held_e_q};

  assign span_w  = (count_q == '0) ? '0 : (tail_q - head_q);
  assign count64 = 64'(count_q);
  assign total64 = 64'(total_q);
  assign span64  = 64'(span_w);

  always_comb begin
    res_o.count  = count64[6:0];
    res_o.total  = total64[47:0];
    res_o.span   = span64[47:0];
    res_o.status = status_q;
  end

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);

  `ASSERT_IMPL(a_no_rw_collide, mem_we && mem_re, w_q != rptr_q, "read and write hit one entry")
  `ASSERT_NEXT(a_done_holds, state_q == S_DONE && !ack_i, state_q == S_DONE, "result dropped")
  `ASSERT_IMPL(a_full_only_at_max, state_q == S_DONE && status_q == ST_FULL,
               count_q == MaxCount, "full status below capacity")
  `ASSERT_IMPL(a_insert_fits, state_q == S_SCAN && phase_q == PH_AFTER,
               abs_q || count_q < MaxCount, "insert into full table")

endmodule

>>> verif/tb_byte_range_set_coalescer_unit.sv
// testbench for byte_range_set_coalescer_unit: drives range inserts over valid/stall
// and checks every result against an in-bench model of the sorted range table
// depends on brsc_pkg and the coalescer rtl
module tb_byte_range_set_coalescer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import brsc_pkg::*;

  localparam int          MAXR        = 64;
  localparam logic [47:0] OFS_LIMIT   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] FILL_BASE   = 48'h7000_0000_0000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [47:0] region_offset_i;
  logic [31:0] region_extent_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [6:0]  range_count_o;
  logic [47:0] covered_bytes_o;
  logic [47:0] covered_span_o;
  logic [1:0]  status_o;

  // model of the range table, updated when a request is accepted
  logic [47:0]  tbl_lo[MAXR];
  logic [47:0]  tbl_hi[MAXR];
  int           tbl_n = 0;
  logic [47:0]  tbl_bytes = '0;
  brsc_result_t pending_results[$];

  int          err_cnt = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req = 1'b0;
  logic [47:0] area_base[8];

  byte_range_set_coalescer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .region_offset_i (region_offset_i),
    .region_extent_i (region_extent_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .range_count_o   (range_count_o),
    .covered_bytes_o (covered_bytes_o),
    .covered_span_o  (covered_span_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic brsc_result_t predict_insert(input logic [47:0] off,
                                                  input logic [31:0] ext);
    brsc_result_t res;
    logic [48:0]  reach;
    logic [47:0]  ns, ne, removed;
    int           n, p, first, j, absorbed, k;
    n = tbl_n;
    reach = {1'b0, off} + {17'b0, ext};
    res.status = ST_OK;
    if (reach > {1'b0, OFS_LIMIT}) begin
      res.status = ST_RANGE;
    end else begin
      ns = off;
      ne = reach[47:0];
      removed = '0;
      p = 0;
      while (p < n && tbl_lo[p] <= off) p++;
      first = p;
      j = p;
      // left neighbour overlaps or touches
      if (p > 0 && off <= tbl_hi[p-1]) begin
        first = p - 1;
        ns = tbl_lo[first];
        if (tbl_hi[first] > ne) ne = tbl_hi[first];
        removed = tbl_hi[first] - tbl_lo[first];
      end
      while (j < n && tbl_lo[j] <= ne) begin
        if (tbl_hi[j] > ne) ne = tbl_hi[j];
        removed = removed + (tbl_hi[j] - tbl_lo[j]);
        j++;
      end
      absorbed = j - first;
      if (absorbed == 0 && n >= MAXR) begin
        res.status = ST_FULL;
      end else begin
        if (absorbed == 0) begin
          for (k = n - 1; k >= j; k--) begin
            tbl_lo[k+1] = tbl_lo[k];
            tbl_hi[k+1] = tbl_hi[k];
          end
        end else if (absorbed > 1) begin
          for (k = j; k < n; k++) begin
            tbl_lo[first+1+k-j] = tbl_lo[k];
            tbl_hi[first+1+k-j] = tbl_hi[k];
          end
        end
        tbl_lo[first] = ns;
        tbl_hi[first] = ne;
        tbl_n = n - absorbed + 1;
        tbl_bytes = tbl_bytes - removed + (ne - ns);
      end
    end
    res.count = tbl_n[6:0];
    res.total = tbl_bytes;
    res.span = (tbl_n > 0) ? tbl_hi[tbl_n-1] - tbl_lo[0] : '0;
    return res;
  endfunction

  task automatic send_region(input logic [47:0] off, input logic [31:0] ext);
    int gap;
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    region_offset_i <= off;
    region_extent_i <= ext;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_insert(off, ext));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
    if (want !== got) begin
      err_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    brsc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $error("result with no request pending: count %0d", range_count_o);
      end else begin
        want = pending_results.pop_front();
        report_field("range_count", {41'b0, want.count}, {41'b0, range_count_o});
        report_field("covered_bytes", want.total, covered_bytes_o);
        report_field("covered_span", want.span, covered_span_o);
        report_field("status", {46'b0, want.status}, {46'b0, status_o});
      end
    end
  end

  task automatic test_directed_edges();
    send_region(48'h0, 32'h0);              // empty range on its own
    send_region(48'h0, 32'd16);             // grows the empty entry
    send_region(48'd16, 32'd8);             // touches on the right
    send_region(48'd40, 32'd8);
    send_region(48'd30, 32'd10);            // end touches the next start
    send_region(48'd24, 32'd6);             // bridges the two
    send_region(48'd4, 32'd2);              // fully contained
    send_region(48'd100, 32'h0);
    send_region(48'd100, 32'h0);
    send_region(48'd1000, 32'hFFFF_FFFF);
    send_region(48'd500, 32'd600);          // overlaps into the big one
    send_region(OFS_LIMIT, 32'h0);          // end exactly at the limit
    send_region(OFS_LIMIT, 32'd1);
    send_region(48'hFFFF_0000_0000, 32'hFFFF_FFFF);
    send_region(48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF);
    send_region(48'h8000_0000_0000, 32'h8000_0000);
    send_region(48'h7FFF_FFFF_FFFF, 32'h1);
    send_region(48'h5555_5555_5555, 32'h5555_5555);
    send_region(48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
  endtask

  task automatic test_table_full();
    int k;
    k = 0;
    while (tbl_n < MAXR) begin
      send_region(FILL_BASE + 48'(k) * 48'd32, 32'd8);
      k++;
    end
    send_region(FILL_BASE - 48'd100, 32'd10);         // isolated, dropped
    send_region(FILL_BASE + 48'd4, 32'd2);            // contained, still fits
    send_region(FILL_BASE + 48'd8, 32'd4);            // touches, merges
    send_region(OFS_LIMIT - 48'd2, 32'd5);            // range check wins
    send_region(FILL_BASE + 48'd20, 32'h0);           // empty but isolated
    send_region(FILL_BASE + 48'd20, 32'd12);          // touches the next entry, merges
    send_region(FILL_BASE, 32'(k) * 32'd32);          // collapse the block
  endtask

  task automatic test_output_backpressure();
    logic [47:0] off;
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (6) begin
      off = 48'h2000_0000 + 48'($urandom_range(0, 4095));
      send_region(off, 32'($urandom_range(0, 63)));
    end
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic run_phase(input int n_items, input logic [47:0] base);
    logic [47:0] off;
    logic [31:0] ext;
    int          r, k, d;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        off = base + 48'($urandom_range(0, 65535));
        ext = (r < 60) ? $urandom_range(0, 255) : $urandom_range(0, 4095);
      end else if (r < 78 && tbl_n > 0) begin
        // land exactly on an edge of a stored range
        k = $urandom_range(0, tbl_n - 1);
        ext = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 1) off = tbl_hi[k];
        else off = (tbl_lo[k] >= 48'(ext)) ? tbl_lo[k] - 48'(ext) : '0;
      end else if (r < 85) begin
        d = $urandom_range(0, 4095);
        off = OFS_LIMIT - 48'(d);
        ext = 32'(d) + $urandom_range(0, 2);
      end else if (r < 92) begin
        off = base + 48'($urandom_range(0, 65535));
        ext = '0;
      end else begin
        off = base + {16'h0, 32'($urandom)};
        ext = $urandom;
      end
      send_region(off, ext);
    end
    // sweep the whole area back into one range
    send_region(base, 32'hFFFF_FFFF);
    send_region(base + 48'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_coalescing();
    logic [13:0] hb;
    for (int i = 0; i < 8; i++) begin
      hb = 14'($urandom_range(0, 14'h3FFE));
      area_base[i] = {hb, 34'h0};
    end
    repeat (19) run_phase(60, area_base[$urandom_range(0, 7)]);
  endtask

  task automatic test_back_to_back();
    wait_drained();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (2) run_phase(50, area_base[$urandom_range(0, 7)]);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    region_offset_i = '0;
    region_extent_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_table_full();
    wait_drained();
    test_output_backpressure();
    test_random_coalescing();
    test_back_to_back();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
